FILE: hw/rtl/lsdsc_pkg.sv
`default_nettype none

package lsdsc_pkg;

    // Default data widths.
    localparam int PIXEL_BITS_DEF  = 8;
    localparam int COLUMN_BITS_DEF = 6;

    // Pixel grouping: the step register and the group counter.
    localparam int STEP_BITS  = 4;
    localparam int GROUP_BITS = 3;
    localparam int STEP_MAX   = 8;

    // Reset values of the configuration registers.
    localparam int SAMPLE_STEP_RST    = 4;
    localparam int EDGE_THRESHOLD_RST = 25;
    localparam int SEARCH_END_RST     = 43;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SAMPLE_STEP    = 2'd0,
        CFG_EDGE_THRESHOLD = 2'd1,
        CFG_SEARCH_END     = 2'd2
    } t_cfg_index;

endpackage

`default_nettype wire

FILE: hw/rtl/lsdsc_in_reg.sv
`default_nettype none

module lsdsc_in_reg
    import lsdsc_pkg::*;
#(
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [PIXEL_BITS-1:0]  i_pixel,
    input  wire logic                   i_line_start,
    input  wire logic                   i_line_end,
    input  wire logic [COLUMN_BITS-1:0] i_start_column,
    input  wire logic [COLUMN_BITS-1:0] i_min_gap,
    input  wire logic [COLUMN_BITS-1:0] i_max_gap,
    input  wire logic                   i_advance,
    output logic                        o_valid,
    output logic [PIXEL_BITS-1:0]       o_pixel,
    output logic                        o_line_start,
    output logic                        o_line_end,
    output logic [COLUMN_BITS-1:0]      o_start_column,
    output logic [COLUMN_BITS-1:0]      o_min_gap,
    output logic [COLUMN_BITS-1:0]      o_max_gap
);

    logic                   r_valid;
    logic [PIXEL_BITS-1:0]  r_pixel;
    logic                   r_line_start;
    logic                   r_line_end;
    logic [COLUMN_BITS-1:0] r_start_column;
    logic [COLUMN_BITS-1:0] r_min_gap;
    logic [COLUMN_BITS-1:0] r_max_gap;
    logic                   w_load;

    // A new word is taken when the register is empty or drains this cycle.
    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload holds until the next accepted word.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pixel        <= i_pixel;
            r_line_start   <= i_line_start;
            r_line_end     <= i_line_end;
            r_start_column <= i_start_column;
            r_min_gap      <= i_min_gap;
            r_max_gap      <= i_max_gap;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel        = r_pixel;
    assign o_line_start   = r_line_start;
    assign o_line_end     = r_line_end;
    assign o_start_column = r_start_column;
    assign o_min_gap      = r_min_gap;
    assign o_max_gap      = r_max_gap;

endmodule

`default_nettype wire

FILE: hw/rtl/lsdsc_core.sv
`default_nettype none

module lsdsc_core
    import lsdsc_pkg::*;
#(
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int CFG_BITS    = (PIXEL_BITS > COLUMN_BITS) ? PIXEL_BITS : COLUMN_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]       i_cfg_data,
    input  wire logic                      i_advance,
    input  wire logic [PIXEL_BITS-1:0]     i_pixel,
    input  wire logic                      i_line_start,
    input  wire logic [COLUMN_BITS-1:0]    i_start_column,
    input  wire logic [COLUMN_BITS-1:0]    i_min_gap,
    input  wire logic [COLUMN_BITS-1:0]    i_max_gap,
    output logic [COLUMN_BITS-1:0]         o_center,
    output logic                           o_found
);

    localparam int unsigned COL_MAX = (1 << COLUMN_BITS) - 1;
    localparam int unsigned PIX_MAX = (1 << PIXEL_BITS) - 1;
    localparam logic [COLUMN_BITS-1:0] SEARCH_END_INIT =
        COLUMN_BITS'((SEARCH_END_RST > COL_MAX) ? COL_MAX : SEARCH_END_RST);
    localparam logic [PIXEL_BITS-1:0] THRESHOLD_INIT =
        PIXEL_BITS'((EDGE_THRESHOLD_RST > PIX_MAX) ? PIX_MAX : EDGE_THRESHOLD_RST);
    localparam logic [PIXEL_BITS-1:0]  PIX_FULL = '1;
    localparam logic [COLUMN_BITS-1:0] COL_FULL = '1;

    // Configuration registers.
    logic [STEP_BITS-1:0]   r_sample_step;
    logic [PIXEL_BITS-1:0]  r_edge_threshold;
    logic [COLUMN_BITS-1:0] r_search_end;

    // Line state.
    logic [GROUP_BITS-1:0]  r_group_count,  n_group_count;
    logic [COLUMN_BITS-1:0] r_column_index, n_column_index;
    logic [PIXEL_BITS-1:0]  r_prev_sample,  n_prev_sample;
    logic [COLUMN_BITS-1:0] r_left_edge,    n_left_edge;
    logic                   r_search_done,  n_search_done;
    logic [COLUMN_BITS-1:0] r_found_center, n_found_center;
    logic [COLUMN_BITS-1:0] r_line_start_column, n_line_start_column;
    logic [COLUMN_BITS-1:0] r_line_min_gap, n_line_min_gap;
    logic [COLUMN_BITS-1:0] r_line_max_gap, n_line_max_gap;

    // Working values after an optional line restart.
    logic [GROUP_BITS-1:0]  w_group;
    logic [COLUMN_BITS-1:0] w_column;
    logic [PIXEL_BITS-1:0]  w_prev;
    logic [COLUMN_BITS-1:0] w_left;
    logic                   w_done;
    logic [COLUMN_BITS-1:0] w_center;
    logic [STEP_BITS-1:0]   w_step;
    logic                   w_take_sample;
    logic                   w_search;
    logic                   w_drop;
    logic                   w_rise;
    logic [COLUMN_BITS:0]   w_width;
    logic [COLUMN_BITS:0]   w_sum;
    logic                   w_width_ok;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_step    <= STEP_BITS'(SAMPLE_STEP_RST);
            r_edge_threshold <= THRESHOLD_INIT;
            r_search_end     <= SEARCH_END_INIT;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SAMPLE_STEP:    r_sample_step    <= i_cfg_data[STEP_BITS-1:0];
                CFG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[PIXEL_BITS-1:0];
                CFG_SEARCH_END:     r_search_end     <= i_cfg_data[COLUMN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Line start restarts the state; the same pixel is then handled normally.
    always_comb begin
        n_line_start_column = i_line_start ? i_start_column : r_line_start_column;
        n_line_min_gap      = i_line_start ? i_min_gap      : r_line_min_gap;
        n_line_max_gap      = i_line_start ? i_max_gap      : r_line_max_gap;
        w_group  = i_line_start ? '0             : r_group_count;
        w_column = i_line_start ? '0             : r_column_index;
        w_prev   = i_line_start ? PIX_FULL       : r_prev_sample;
        w_left   = i_line_start ? i_start_column : r_left_edge;
        w_done   = i_line_start ? 1'b0           : r_search_done;
        w_center = i_line_start ? '0             : r_found_center;
    end

    // Step clamped to 1..8; the last pixel of each group is the sample.
    always_comb begin
        if (r_sample_step == '0) begin
            w_step = STEP_BITS'(1);
        end else if (r_sample_step > STEP_BITS'(STEP_MAX)) begin
            w_step = STEP_BITS'(STEP_MAX);
        end else begin
            w_step = r_sample_step;
        end
        w_take_sample = ({1'b0, w_group} + STEP_BITS'(1)) >= w_step;
    end

    // Edge tests on the true difference of previous sample and pixel.
    always_comb begin
        w_search = w_take_sample && !w_done && (w_column >= n_line_start_column)
                   && (w_column < r_search_end);
        w_drop   = {1'b0, w_prev} > ({1'b0, i_pixel} + {1'b0, r_edge_threshold});
        w_rise   = {1'b0, i_pixel} > ({1'b0, w_prev} + {1'b0, r_edge_threshold});
        w_width  = {1'b0, w_column} - {1'b0, w_left};
        w_sum    = {1'b0, w_left} + {1'b0, w_column};
        w_width_ok = ($signed(w_width) > $signed({1'b0, n_line_min_gap}))
                     && ($signed(w_width) < $signed({1'b0, n_line_max_gap}));
    end

    // Next line state.
    always_comb begin
        n_prev_sample  = w_prev;
        n_left_edge    = w_left;
        n_search_done  = w_done;
        n_found_center = w_center;
        if (w_search) begin
            n_prev_sample = i_pixel;
            if (w_drop) begin
                n_left_edge = w_column;
            end
            if (w_rise && w_width_ok) begin
                n_found_center = w_sum[COLUMN_BITS:1];
                n_search_done  = 1'b1;
            end
        end
        if (w_take_sample) begin
            n_group_count  = '0;
            n_column_index = (w_column != COL_FULL) ? w_column + COLUMN_BITS'(1) : w_column;
        end else begin
            n_group_count  = w_group + GROUP_BITS'(1);
            n_column_index = w_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count       <= '0;
            r_column_index      <= '0;
            r_prev_sample       <= PIX_FULL;
            r_left_edge         <= '0;
            r_search_done       <= 1'b0;
            r_found_center      <= '0;
            r_line_start_column <= '0;
            r_line_min_gap      <= '0;
            r_line_max_gap      <= '0;
        end else if (i_advance) begin
            r_group_count       <= n_group_count;
            r_column_index      <= n_column_index;
            r_prev_sample       <= n_prev_sample;
            r_left_edge         <= n_left_edge;
            r_search_done       <= n_search_done;
            r_found_center      <= n_found_center;
            r_line_start_column <= n_line_start_column;
            r_line_min_gap      <= n_line_min_gap;
            r_line_max_gap      <= n_line_max_gap;
        end
    end

    // Result of the current word, used only on the last pixel of a line.
    assign o_found  = n_search_done;
    assign o_center = n_search_done ? n_found_center : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/lsdsc_out_reg.sv
`default_nettype none

module lsdsc_out_reg
    import lsdsc_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [COLUMN_BITS-1:0] i_center,
    input  wire logic                   i_found,
    input  wire logic                   i_ready,
    output logic                        o_can_load,
    output logic                        o_valid,
    output logic [COLUMN_BITS-1:0]      o_center,
    output logic                        o_found
);

    logic                   r_valid;
    logic [COLUMN_BITS-1:0] r_center;
    logic                   r_found;

    // Room for a result when empty or when the held word leaves now.
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_center <= i_center;
            r_found  <= i_found;
        end
    end

    assign o_valid  = r_valid;
    assign o_center = r_center;
    assign o_found  = r_found;

endmodule

`default_nettype wire

FILE: hw/rtl/line_scan_dark_stripe_center_top.sv
// Channel   Dir  tdata (low bit up)                              tuser       tlast
// s_axis    in   pixel, start_column, min_gap, max_gap, zeros    line_start  line_end
// m_axis    out  center, zeros                                   found       -
// cfg       in   i_cfg_we, i_cfg_index (0 step, 1 threshold, 2 search end), i_cfg_data
//
// One pixel word is taken every cycle unless a held line end waits for the result slot;
// a result passes the input register, then the result register.
// The sample and edge logic lies between those two registers.
// Reset is synchronous and active low and restores the register defaults.
// A full result slot holds back only a word that ends a line; other pixels move on, but new words wait behind it.
`default_nettype none

module line_scan_dark_stripe_center_top
    import lsdsc_pkg::*;
#(
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int CFG_BITS    = (PIXEL_BITS > COLUMN_BITS) ? PIXEL_BITS : COLUMN_BITS,
    parameter int IN_BITS     = PIXEL_BITS + 3 * COLUMN_BITS,
    parameter int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
    parameter int OUT_TDATA_W = ((COLUMN_BITS + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]       i_cfg_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]     s_axis_tdata,  // pixel, start_column, min_gap, max_gap
    input  wire logic                      s_axis_tuser,  // line_start
    input  wire logic                      s_axis_tlast,  // line_end
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata,  // center
    output logic                           m_axis_tuser   // found
);

    localparam int START_LO = PIXEL_BITS;
    localparam int MIN_LO   = PIXEL_BITS + COLUMN_BITS;
    localparam int MAX_LO   = PIXEL_BITS + 2 * COLUMN_BITS;

    logic                   w_in_valid;
    logic [PIXEL_BITS-1:0]  w_pixel;
    logic                   w_line_start;
    logic                   w_line_end;
    logic [COLUMN_BITS-1:0] w_start_column;
    logic [COLUMN_BITS-1:0] w_min_gap;
    logic [COLUMN_BITS-1:0] w_max_gap;
    logic                   w_advance;
    logic                   w_can_load;
    logic [COLUMN_BITS-1:0] w_core_center;
    logic                   w_core_found;
    logic [COLUMN_BITS-1:0] w_out_center;

    // The held word moves on unless it ends a line and the result slot is full.
    assign w_advance = w_in_valid && (!w_line_end || w_can_load);

    lsdsc_in_reg #(
        .PIXEL_BITS  (PIXEL_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_in_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_pixel        (s_axis_tdata[PIXEL_BITS-1:0]),
        .i_line_start   (s_axis_tuser),
        .i_line_end     (s_axis_tlast),
        .i_start_column (s_axis_tdata[START_LO +: COLUMN_BITS]),
        .i_min_gap      (s_axis_tdata[MIN_LO +: COLUMN_BITS]),
        .i_max_gap      (s_axis_tdata[MAX_LO +: COLUMN_BITS]),
        .i_advance      (w_advance),
        .o_valid        (w_in_valid),
        .o_pixel        (w_pixel),
        .o_line_start   (w_line_start),
        .o_line_end     (w_line_end),
        .o_start_column (w_start_column),
        .o_min_gap      (w_min_gap),
        .o_max_gap      (w_max_gap)
    );

    lsdsc_core #(
        .PIXEL_BITS  (PIXEL_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_advance      (w_advance),
        .i_pixel        (w_pixel),
        .i_line_start   (w_line_start),
        .i_start_column (w_start_column),
        .i_min_gap      (w_min_gap),
        .i_max_gap      (w_max_gap),
        .o_center       (w_core_center),
        .o_found        (w_core_found)
    );

    lsdsc_out_reg #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_line_end),
        .i_center   (w_core_center),
        .i_found    (w_core_found),
        .i_ready    (m_axis_tready),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .o_center   (w_out_center),
        .o_found    (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_out_center);

endmodule

`default_nettype wire
